// ----- hdl/matrix3_inverse_assert.svh -----
// Assertion macros for the 3x3 matrix inverse block.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH
`ifndef SYNTHESIS
`define M3I_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define M3I_ASSERT(lbl, prop, msg)
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/m3i_pkg.sv -----
// Shared types and constants of the 3x3 matrix inverse block.
// Depends on nothing; used by the front end, the divider lanes and the top level.
`default_nettype none
package m3i_pkg;
	localparam int NUM_ELEM = 9;

	// Diagonal positions in element order (index 3*column + row).
	localparam logic [NUM_ELEM-1:0] IDENT_MASK = 9'b100010001;

	// Per-lane control that travels with the divider data.
	typedef struct packed {
		logic neg;
		logic ovf;
		logic zero;
	} m3i_ctrl_t;
endpackage
`default_nettype wire

// ----- hdl/m3i_front.sv -----
// Front end: cofactors, determinant, and divider operands for the nine lanes.
// Uses m3i_pkg for the lane control struct.
`default_nettype none
module m3i_front #(
	parameter int E = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [E-1:0]   elem [m3i_pkg::NUM_ELEM],
	output logic [4*E+2:0]        num [m3i_pkg::NUM_ELEM],
	output logic [3*E+2:0]        dmag,
	output m3i_pkg::m3i_ctrl_t    ctrl [m3i_pkg::NUM_ELEM]
);
	localparam int W2   = 2 * E + 1;
	localparam int DW   = 3 * E + 3;
	localparam int RW   = DW + E;
	localparam int NUMW = W2 + 2 * F;
	localparam int CW   = ((NUMW > RW) ? NUMW : RW) + 1;

	logic signed [2*E-1:0] t1_s1 [m3i_pkg::NUM_ELEM];
	logic signed [2*E-1:0] t2_s1 [m3i_pkg::NUM_ELEM];
	logic signed [E-1:0]   m0_s1 [3];
	logic signed [W2-1:0]  cof_s2 [m3i_pkg::NUM_ELEM];
	logic signed [E-1:0]   m0_s2 [3];
	logic signed [W2-1:0]  cof_s3 [m3i_pkg::NUM_ELEM];
	logic signed [W2-1:0]  pplo_s3 [3];
	logic signed [W2-1:0]  pphi_s3 [3];
	logic signed [W2-1:0]  cof_s4 [m3i_pkg::NUM_ELEM];
	logic [DW-1:0]         det_s4;
	logic [DW-1:0]         det_sum;
	logic [DW-1:0]         dmag_c;
	logic [RW-1:0]         num_c [m3i_pkg::NUM_ELEM];
	m3i_pkg::m3i_ctrl_t    ctrl_c [m3i_pkg::NUM_ELEM];
	logic [RW-1:0]         num_s5 [m3i_pkg::NUM_ELEM];
	logic [DW-1:0]         dmag_s5;
	m3i_pkg::m3i_ctrl_t    ctrl_s5 [m3i_pkg::NUM_ELEM];

	// Stage 1: the two products of every 2x2 minor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					t1_s1[3*c+r] <= elem[3*((c == 0) ? 1 : 0) + ((r == 0) ? 1 : 0)]
						* elem[3*((c == 2) ? 1 : 2) + ((r == 2) ? 1 : 2)];
					t2_s1[3*c+r] <= elem[3*((c == 2) ? 1 : 2) + ((r == 0) ? 1 : 0)]
						* elem[3*((c == 0) ? 1 : 0) + ((r == 2) ? 1 : 2)];
				end
			end
			for (int c = 0; c < 3; c++) begin
				m0_s1[c] <= elem[3*c];
			end
		end
	end

	// Stage 2: signed cofactors; index is 3*row + column of the cofactor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (((r + c) % 2) == 1) begin
						cof_s2[3*r+c] <= $signed({t2_s1[3*c+r][2*E-1], t2_s1[3*c+r]})
							- $signed({t1_s1[3*c+r][2*E-1], t1_s1[3*c+r]});
					end else begin
						cof_s2[3*r+c] <= $signed({t1_s1[3*c+r][2*E-1], t1_s1[3*c+r]})
							- $signed({t2_s1[3*c+r][2*E-1], t2_s1[3*c+r]});
					end
				end
			end
			m0_s2 <= m0_s1;
		end
	end

	// Stage 3: row 0 times its cofactors, split into low and high partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pplo_s3[c] <= m0_s2[c] * $signed({1'b0, cof_s2[c][E-1:0]});
				pphi_s3[c] <= m0_s2[c] * $signed(cof_s2[c][W2-1:E]);
			end
			cof_s3 <= cof_s2;
		end
	end

	always_comb begin
		det_sum = '0;
		for (int c = 0; c < 3; c++) begin
			det_sum = det_sum + ({{(DW-W2){pphi_s3[c][W2-1]}}, pphi_s3[c]} << E)
				+ {{(DW-W2){pplo_s3[c][W2-1]}}, pplo_s3[c]};
		end
	end

	// Stage 4: determinant.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= det_sum;
			cof_s4 <= cof_s3;
		end
	end

	// Stage 5: magnitudes, signs and the early overflow test of every quotient.
	always_comb begin
		logic [W2-1:0]   amag;
		logic [CW-1:0]   numw;
		logic [CW-1:0]   dlim;
		logic            dneg;
		dneg   = det_s4[DW-1];
		dmag_c = dneg ? (~det_s4 + {{(DW-1){1'b0}}, 1'b1}) : det_s4;
		dlim   = {{(CW-RW){1'b0}}, dmag_c, {E{1'b0}}};
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				amag = cof_s4[3*c+r][W2-1] ? (~cof_s4[3*c+r] + {{(W2-1){1'b0}}, 1'b1})
					: cof_s4[3*c+r];
				numw = {{(CW-NUMW){1'b0}}, amag, {(2*F){1'b0}}};
				num_c[3*c+r]       = numw[RW-1:0];
				ctrl_c[3*c+r].neg  = cof_s4[3*c+r][W2-1] ^ dneg;
				ctrl_c[3*c+r].ovf  = (numw >= dlim);
				ctrl_c[3*c+r].zero = (det_s4 == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5  <= num_c;
			dmag_s5 <= dmag_c;
			ctrl_s5 <= ctrl_c;
		end
	end

	assign num  = num_s5;
	assign dmag = dmag_s5;
	assign ctrl = ctrl_s5;
endmodule
`default_nettype wire

// ----- hdl/m3i_lane.sv -----
// One divider lane: pipelined restoring division, one quotient bit per stage, then clipping.
// Uses m3i_pkg for the lane control struct.
`default_nettype none
module m3i_lane #(
	parameter int E    = 32,
	parameter int F    = 16,
	parameter bit DIAG = 1'b0
) (
	input  logic               clk,
	input  logic               en,
	input  logic [4*E+2:0]     num,
	input  logic [3*E+2:0]     dmag,
	input  m3i_pkg::m3i_ctrl_t ctrl,
	output logic [E-1:0]       elem,
	output logic               sat,
	output logic               sing
);
	localparam int DW = 3 * E + 3;
	localparam int RW = DW + E;
	localparam logic [E-1:0] POS_LIM = {1'b0, {(E-1){1'b1}}};
	localparam logic [E-1:0] NEG_MAG = {1'b1, {(E-1){1'b0}}};
	localparam bit           ONE_SAT = (F > E - 2);
	localparam logic [E-1:0] ONE_VAL = ONE_SAT ? POS_LIM : ({{(E-1){1'b0}}, 1'b1} << F);

	logic [RW-1:0]      rem_s  [1:E];
	logic [DW-1:0]      dmag_s [1:E];
	logic [E-1:0]       q_s    [1:E];
	m3i_pkg::m3i_ctrl_t ctrl_s [1:E];

	for (genvar j = 0; j < E; j++) begin : g_st
		logic [RW-1:0]      r_in;
		logic [DW-1:0]      d_in;
		logic [E-1:0]       q_in;
		m3i_pkg::m3i_ctrl_t c_in;
		logic [RW-1:0]      trial;
		logic               ge;
		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = dmag;
			assign q_in = '0;
			assign c_in = ctrl;
		end else begin : g_rest
			assign r_in = rem_s[j];
			assign d_in = dmag_s[j];
			assign q_in = q_s[j];
			assign c_in = ctrl_s[j];
		end
		assign trial = {{E{1'b0}}, d_in} << (E - 1 - j);
		assign ge    = (r_in >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? (r_in - trial) : r_in;
				q_s[j+1]    <= q_in | ({{(E-1){1'b0}}, ge} << (E - 1 - j));
				dmag_s[j+1] <= d_in;
				ctrl_s[j+1] <= c_in;
			end
		end
	end

	always_comb begin
		logic          over;
		logic [E-1:0]  mag;
		over = ctrl_s[E].ovf || (ctrl_s[E].neg ? (q_s[E] > NEG_MAG) : (q_s[E] > POS_LIM));
		mag  = over ? (ctrl_s[E].neg ? NEG_MAG : POS_LIM) : q_s[E];
		if (ctrl_s[E].zero) begin
			elem = DIAG ? ONE_VAL : '0;
			sat  = DIAG && ONE_SAT;
		end else begin
			elem = ctrl_s[E].neg ? (~mag + {{(E-1){1'b0}}, 1'b1}) : mag;
			sat  = over;
		end
		sing = ctrl_s[E].zero;
	end
endmodule
`default_nettype wire

// ----- hdl/matrix3_inverse.sv -----
// Top level of the 3x3 matrix inverse: front end, nine divider lanes and the result register.
// Depends on m3i_pkg, m3i_front, m3i_lane and matrix3_inverse_assert.svh.
//
// The block inverts one 3x3 matrix of signed fixed-point elements (Q16.16 at the default
// sizes) per beat. A five-stage front end forms the 2x2 minors, the cofactors and the
// determinant exactly, with every multiplier no wider than an element by one bit more. Nine
// identical divider lanes then divide each adjugate entry, scaled up by two times FRAC_BITS,
// by the determinant magnitude with a restoring divider that resolves one quotient bit per
// stage; a quotient that would not fit ELEM_WIDTH bits is caught before the divider and
// clipped. A final register merges the lanes: it raises saturated when any lane clipped and
// singular when the determinant is exactly zero, in which case the result is the identity.
// A new matrix is taken every cycle while in_stall is low; from an accepted input beat the
// data passes the five front stages, one divider stage per quotient bit and the output
// register to the result beat. The pipeline moves as a whole: while a result is shown and
// stalled, in_stall is high and no stage advances.
`default_nettype none
module matrix3_inverse #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [ELEM_WIDTH-1:0] in_r0_c0,
	input  logic signed [ELEM_WIDTH-1:0] in_r1_c0,
	input  logic signed [ELEM_WIDTH-1:0] in_r2_c0,
	input  logic signed [ELEM_WIDTH-1:0] in_r0_c1,
	input  logic signed [ELEM_WIDTH-1:0] in_r1_c1,
	input  logic signed [ELEM_WIDTH-1:0] in_r2_c1,
	input  logic signed [ELEM_WIDTH-1:0] in_r0_c2,
	input  logic signed [ELEM_WIDTH-1:0] in_r1_c2,
	input  logic signed [ELEM_WIDTH-1:0] in_r2_c2,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ELEM_WIDTH-1:0] out_r0_c0,
	output logic signed [ELEM_WIDTH-1:0] out_r1_c0,
	output logic signed [ELEM_WIDTH-1:0] out_r2_c0,
	output logic signed [ELEM_WIDTH-1:0] out_r0_c1,
	output logic signed [ELEM_WIDTH-1:0] out_r1_c1,
	output logic signed [ELEM_WIDTH-1:0] out_r2_c1,
	output logic signed [ELEM_WIDTH-1:0] out_r0_c2,
	output logic signed [ELEM_WIDTH-1:0] out_r1_c2,
	output logic signed [ELEM_WIDTH-1:0] out_r2_c2,
	output logic                         singular,
	output logic                         saturated
);
	localparam int DW  = 3 * ELEM_WIDTH + 3;
	localparam int RW  = DW + ELEM_WIDTH;
	// Register stages ahead of the output register: five front stages plus one per quotient bit.
	localparam int LAT = 5 + ELEM_WIDTH;

	logic                          en;
	logic [LAT-1:0]                vld_q;
	logic                          out_valid_q;
	logic signed [ELEM_WIDTH-1:0]  elem_in [m3i_pkg::NUM_ELEM];
	logic [RW-1:0]                 num [m3i_pkg::NUM_ELEM];
	logic [DW-1:0]                 dmag;
	m3i_pkg::m3i_ctrl_t            ctrl [m3i_pkg::NUM_ELEM];
	logic [ELEM_WIDTH-1:0]         lane_elem [m3i_pkg::NUM_ELEM];
	logic [m3i_pkg::NUM_ELEM-1:0]  lane_sat;
	logic [m3i_pkg::NUM_ELEM-1:0]  lane_sing;
	logic [ELEM_WIDTH-1:0]         elem_q [m3i_pkg::NUM_ELEM];
	logic                          sing_q;
	logic                          sat_q;

	// The whole pipeline advances unless a result beat is waiting on a stalled receiver.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Element order is 3*column + row, the same in every lane.
	assign elem_in[0] = in_r0_c0;
	assign elem_in[1] = in_r1_c0;
	assign elem_in[2] = in_r2_c0;
	assign elem_in[3] = in_r0_c1;
	assign elem_in[4] = in_r1_c1;
	assign elem_in[5] = in_r2_c1;
	assign elem_in[6] = in_r0_c2;
	assign elem_in[7] = in_r1_c2;
	assign elem_in[8] = in_r2_c2;

	m3i_front #(
		.E(ELEM_WIDTH),
		.F(FRAC_BITS)
	) u_front (
		.clk  (clk),
		.en   (en),
		.elem (elem_in),
		.num  (num),
		.dmag (dmag),
		.ctrl (ctrl)
	);

	// One divider lane per inverse element; diagonal lanes know the identity's one.
	for (genvar k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_lane
		m3i_lane #(
			.E    (ELEM_WIDTH),
			.F    (FRAC_BITS),
			.DIAG (m3i_pkg::IDENT_MASK[k])
		) u_lane (
			.clk  (clk),
			.en   (en),
			.num  (num[k]),
			.dmag (dmag),
			.ctrl (ctrl[k]),
			.elem (lane_elem[k]),
			.sat  (lane_sat[k]),
			.sing (lane_sing[k])
		);
	end

	// Valid bits run alongside the data; they are the only state that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], in_valid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// Merging stage: collect the lane results and combine their flags.
	always_ff @(posedge clk) begin
		if (en) begin
			elem_q <= lane_elem;
			sing_q <= lane_sing[0];
			sat_q  <= |lane_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_r0_c0 = elem_q[0];
	assign out_r1_c0 = elem_q[1];
	assign out_r2_c0 = elem_q[2];
	assign out_r0_c1 = elem_q[3];
	assign out_r1_c1 = elem_q[4];
	assign out_r2_c1 = elem_q[5];
	assign out_r0_c2 = elem_q[6];
	assign out_r1_c2 = elem_q[7];
	assign out_r2_c2 = elem_q[8];
	assign singular  = sing_q;
	assign saturated = sat_q;

`include "matrix3_inverse_assert.svh"

	`M3I_ASSERT(a_sing_offdiag, (out_valid && singular) |-> (out_r1_c0 == '0 && out_r0_c1 == '0 && out_r2_c1 == '0), "singular result has nonzero off-diagonal element")
	`M3I_ASSERT_NEXT(a_out_follows_pipe, !out_stall, out_valid == $past(vld_q[LAT-1]), "result valid does not follow the pipeline")
	`M3I_ASSERT_NEXT(a_frozen_hold, out_valid && out_stall, vld_q == $past(vld_q), "pipeline moved while the result was stalled")
endmodule
`default_nettype wire
